/* src/ogg_page_parse_verify_unit_assert.svh */
// Assertion macros for the port-level checker of the Ogg page parser.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef OGG_PAGE_PARSE_VERIFY_UNIT_ASSERT_SVH
`define OGG_PAGE_PARSE_VERIFY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OGPV_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ogpv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OGPV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ogpv assertion failed");

`endif

/* src/ogpv_pkg.sv */
// Package for the Ogg page parser: phase and status codes, header offsets,
// the result record and the CRC-32 byte step. No dependencies.
package ogpv_pkg;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SEGS   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIG  = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;
    localparam logic [1:0] STATUS_TRUNC    = 2'd3;

    localparam logic [4:0] HDR_LEN       = 5'd27;
    localparam logic [4:0] HDR_LAST      = 5'd26;
    localparam logic [4:0] IDX_VERSION   = 5'd4;
    localparam logic [4:0] IDX_TYPE      = 5'd5;
    localparam int         IDX_GRANULE   = 6;
    localparam int         IDX_SERIAL    = 14;
    localparam int         IDX_SEQUENCE  = 18;
    localparam int         IDX_CRC       = 22;
    localparam logic [4:0] IDX_SYNC_END  = 5'd4;

    localparam logic [31:0] CRC_POLY = 32'h04c11db7;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        page_done;
        logic [1:0]  status;
        logic [7:0]  version;
        logic [7:0]  page_type;
        logic [63:0] granule_position;
        logic [31:0] serial_number;
        logic [31:0] sequence_number;
        logic [15:0] data_length;
        logic [7:0]  segment_count;
    } result_t;

    function automatic logic [7:0] sync_byte(input logic [1:0] i);
        logic [7:0] v;
        case (i)
            2'd0: v = 8'h4f;
            2'd1: v = 8'h67;
            2'd2: v = 8'h67;
            default: v = 8'h53;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* src/ogpv_core.sv */
// Parse state of the Ogg page parser: header capture, segment table sum,
// payload count and running CRC. Depends on ogpv_pkg.
module ogpv_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       stream_byte,
    input  logic             end_of_input,
    output logic             emit,
    output ogpv_pkg::result_t result
);
    import ogpv_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  hidx_reg, hidx_next;
    logic        sig_reg, sig_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [63:0] granule_reg, granule_next;
    logic [31:0] serial_reg, serial_next;
    logic [31:0] sequence_reg, sequence_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic [7:0]  seg_total_reg, seg_total_next;
    logic [7:0]  seg_seen_reg, seg_seen_next;
    logic [15:0] len_sum_reg, len_sum_next;
    logic [15:0] left_reg, left_next;
    logic [31:0] crc_reg, crc_next;

    logic [4:0] idx;
    logic       pv, done, finish;
    logic [1:0] status;
    logic [7:0] pb;

    always_comb begin
        phase_next      = phase_reg;
        hidx_next       = hidx_reg;
        sig_next        = sig_reg;
        version_next    = version_reg;
        type_next       = type_reg;
        granule_next    = granule_reg;
        serial_next     = serial_reg;
        sequence_next   = sequence_reg;
        stored_crc_next = stored_crc_reg;
        seg_total_next  = seg_total_reg;
        seg_seen_next   = seg_seen_reg;
        len_sum_next    = len_sum_reg;
        left_next       = left_reg;
        crc_next        = crc_reg;
        idx             = 5'd0;
        pv              = 1'b0;
        pb              = 8'h00;
        done            = 1'b0;
        finish          = 1'b0;
        status          = STATUS_OK;
        case (phase_reg)
            PH_SEGS: begin
                crc_next      = crc_byte(crc_reg, stream_byte);
                len_sum_next  = len_sum_reg + {8'h00, stream_byte};
                seg_seen_next = seg_seen_reg + 8'd1;
                if (seg_seen_next == seg_total_reg) begin
                    if (len_sum_next == 16'd0) begin
                        finish = 1'b1;
                    end else begin
                        left_next  = len_sum_next;
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                crc_next  = crc_byte(crc_reg, stream_byte);
                pv        = 1'b1;
                pb        = stream_byte;
                left_next = left_reg - 16'd1;
                if (left_next == 16'd0) begin
                    finish = 1'b1;
                end
            end
            default: begin
                idx = (hidx_reg >= HDR_LEN) ? 5'd0 : hidx_reg;
                if (idx == 5'd0) begin
                    sig_next        = 1'b1;
                    version_next    = 8'h00;
                    type_next       = 8'h00;
                    granule_next    = 64'h0;
                    serial_next     = 32'h0;
                    sequence_next   = 32'h0;
                    stored_crc_next = 32'h0;
                    seg_total_next  = 8'h00;
                    seg_seen_next   = 8'h00;
                    len_sum_next    = 16'h0000;
                    left_next       = 16'h0000;
                    crc_next        = 32'h0;
                end
                crc_next = crc_byte(crc_next, (idx inside {[5'd22:5'd25]}) ? 8'h00 : stream_byte);
                if (idx < IDX_SYNC_END && stream_byte != sync_byte(idx[1:0])) begin
                    sig_next = 1'b0;
                end
                if (idx == IDX_VERSION) begin
                    version_next = stream_byte;
                end
                if (idx == IDX_TYPE) begin
                    type_next = stream_byte;
                end
                for (int k = 0; k < 8; k++) begin
                    if (idx == 5'(IDX_GRANULE + k)) begin
                        granule_next[8*k +: 8] = granule_next[8*k +: 8] | stream_byte;
                    end
                end
                for (int k = 0; k < 4; k++) begin
                    if (idx == 5'(IDX_SERIAL + k)) begin
                        serial_next[8*k +: 8] = serial_next[8*k +: 8] | stream_byte;
                    end
                    if (idx == 5'(IDX_SEQUENCE + k)) begin
                        sequence_next[8*k +: 8] = sequence_next[8*k +: 8] | stream_byte;
                    end
                    if (idx == 5'(IDX_CRC + k)) begin
                        stored_crc_next[8*k +: 8] = stored_crc_next[8*k +: 8] | stream_byte;
                    end
                end
                if (idx == HDR_LAST) begin
                    seg_total_next = stream_byte;
                    hidx_next      = 5'd0;
                    phase_next     = PH_HEADER;
                    if (!sig_next) begin
                        done   = 1'b1;
                        status = STATUS_BAD_SIG;
                    end else if (stream_byte == 8'h00) begin
                        finish = 1'b1;
                    end else begin
                        seg_seen_next = 8'h00;
                        len_sum_next  = 16'h0000;
                        phase_next    = PH_SEGS;
                    end
                end else begin
                    hidx_next  = idx + 5'd1;
                    phase_next = PH_HEADER;
                end
            end
        endcase
        if (finish) begin
            done       = 1'b1;
            status     = (crc_next == stored_crc_next) ? STATUS_OK : STATUS_MISMATCH;
            phase_next = PH_HEADER;
            hidx_next  = 5'd0;
        end
        if (!done && end_of_input) begin
            done       = 1'b1;
            status     = STATUS_TRUNC;
            phase_next = PH_HEADER;
            hidx_next  = 5'd0;
        end
    end

    assign emit = done || pv;

    always_comb begin
        result.payload_valid    = pv;
        result.payload_byte     = pb;
        result.page_done        = done;
        result.status           = done ? status : STATUS_OK;
        result.version          = version_next;
        result.page_type        = type_next;
        result.granule_position = granule_next;
        result.serial_number    = serial_next;
        result.sequence_number  = sequence_next;
        result.data_length      = len_sum_next;
        result.segment_count    = seg_total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hidx_reg       <= 5'd0;
            sig_reg        <= 1'b1;
            version_reg    <= 8'h00;
            type_reg       <= 8'h00;
            granule_reg    <= 64'h0;
            serial_reg     <= 32'h0;
            sequence_reg   <= 32'h0;
            stored_crc_reg <= 32'h0;
            seg_total_reg  <= 8'h00;
            seg_seen_reg   <= 8'h00;
            len_sum_reg    <= 16'h0000;
            left_reg       <= 16'h0000;
            crc_reg        <= 32'h0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            hidx_reg       <= hidx_next;
            sig_reg        <= sig_next;
            version_reg    <= version_next;
            type_reg       <= type_next;
            granule_reg    <= granule_next;
            serial_reg     <= serial_next;
            sequence_reg   <= sequence_next;
            stored_crc_reg <= stored_crc_next;
            seg_total_reg  <= seg_total_next;
            seg_seen_reg   <= seg_seen_next;
            len_sum_reg    <= len_sum_next;
            left_reg       <= left_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

/* src/ogpv_out_reg.sv */
// Result register of the Ogg page parser with the request handshake.
// Depends on ogpv_pkg for the result record.
module ogpv_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              emit,
    input  ogpv_pkg::result_t result_in,
    input  logic              m_ready,
    output logic              m_valid,
    output logic              s_ready,
    output ogpv_pkg::result_t result_out
);
    import ogpv_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign s_ready    = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign result_out = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = emit;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            data_reg <= result_in;
        end
    end

endmodule

/* src/ogg_page_parse_verify_unit.sv */
// A result is registered; it appears in the cycle after its stream byte is accepted.
// One byte per cycle while s_ready is high; the CRC step and counters update on accept.
// A byte is accepted while a finished result waits, as long as m_ready takes it.
// Reset (aresetn low, synchronous) returns to the header phase and empties the result
// register. Depends on ogpv_pkg, ogpv_core and ogpv_out_reg.
module ogg_page_parse_verify_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic        m_page_done,
    output logic [1:0]  m_status,
    output logic [7:0]  m_version,
    output logic [7:0]  m_page_type,
    output logic [63:0] m_granule_position,
    output logic [31:0] m_serial_number,
    output logic [31:0] m_sequence_number,
    output logic [15:0] m_data_length,
    output logic [7:0]  m_segment_count
);
    import ogpv_pkg::*;

    logic    accept;
    logic    emit;
    result_t core_result;
    result_t out_result;

    assign accept = s_valid && s_ready;

    ogpv_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .stream_byte (s_stream_byte),
        .end_of_input(s_end_of_input),
        .emit        (emit),
        .result      (core_result)
    );

    ogpv_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .emit      (emit),
        .result_in (core_result),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .s_ready   (s_ready),
        .result_out(out_result)
    );

    assign m_payload_valid    = out_result.payload_valid;
    assign m_payload_byte     = out_result.payload_byte;
    assign m_page_done        = out_result.page_done;
    assign m_status           = out_result.status;
    assign m_version          = out_result.version;
    assign m_page_type        = out_result.page_type;
    assign m_granule_position = out_result.granule_position;
    assign m_serial_number    = out_result.serial_number;
    assign m_sequence_number  = out_result.sequence_number;
    assign m_data_length      = out_result.data_length;
    assign m_segment_count    = out_result.segment_count;

endmodule

/* src/ogpv_checker.sv */
// Port-level checker for the Ogg page parser, bound to the top level.
// Depends on ogpv_pkg and ogg_page_parse_verify_unit_assert.svh.
`include "ogg_page_parse_verify_unit_assert.svh"

module ogpv_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_payload_valid,
    input logic [7:0] m_payload_byte,
    input logic       m_page_done,
    input logic [1:0] m_status
);
    import ogpv_pkg::*;

    `OGPV_ASSERT_IMPLY(a_result_has_content, m_valid, m_payload_valid || m_page_done)
    `OGPV_ASSERT_IMPLY(a_status_only_when_done, m_valid && !m_page_done, m_status == STATUS_OK)
    `OGPV_ASSERT_IMPLY(a_no_byte_without_payload, m_valid && !m_payload_valid, m_payload_byte == 8'h00)
    `OGPV_ASSERT_IMPLY(a_ready_when_empty, !m_valid, s_ready)
    `OGPV_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid)

endmodule

bind ogg_page_parse_verify_unit ogpv_checker u_ogpv_checker (.*);

/* bench/tb_ogg_page_parse_verify_unit.sv */
// Self-checking testbench for the Ogg page parser and CRC checker: builds pages, streams
// them byte by byte with random idling on both sides and checks every result record.
// Depends on ogpv_pkg and ogg_page_parse_verify_unit.
`timescale 1ns / 1ps

module tb_ogg_page_parse_verify_unit;
    import ogpv_pkg::*;

    localparam logic [7:0] CAPTURE_PATTERN [4] = '{8'h4f, 8'h67, 8'h67, 8'h53};
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int NO_LACE     = -1;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_stream_byte;
    logic        s_end_of_input;
    logic        m_valid;
    logic        m_ready;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic        m_page_done;
    logic [1:0]  m_status;
    logic [7:0]  m_version;
    logic [7:0]  m_page_type;
    logic [63:0] m_granule_position;
    logic [31:0] m_serial_number;
    logic [31:0] m_sequence_number;
    logic [15:0] m_data_length;
    logic [7:0]  m_segment_count;

    ogg_page_parse_verify_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_stream_byte      (s_stream_byte),
        .s_end_of_input     (s_end_of_input),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_payload_valid    (m_payload_valid),
        .m_payload_byte     (m_payload_byte),
        .m_page_done        (m_page_done),
        .m_status           (m_status),
        .m_version          (m_version),
        .m_page_type        (m_page_type),
        .m_granule_position (m_granule_position),
        .m_serial_number    (m_serial_number),
        .m_sequence_number  (m_sequence_number),
        .m_data_length      (m_data_length),
        .m_segment_count    (m_segment_count)
    );

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int bytes_sent = 0;

    result_t    expected_results [$];
    logic [7:0] page_bytes [$];

    logic [1:0]  parse_phase;
    logic [4:0]  header_pos;
    logic        sync_ok;
    logic [7:0]  version_q;
    logic [7:0]  page_type_q;
    logic [63:0] granule_q;
    logic [31:0] serial_q;
    logic [31:0] sequence_q;
    logic [31:0] crc_in_header;
    logic [7:0]  seg_total;
    logic [7:0]  seg_seen;
    logic [15:0] length_total;
    logic [15:0] payload_left;
    logic [31:0] page_crc;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [31:0] page_crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ 32'h04c11db7) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

    task automatic clear_page_state();
        sync_ok = 1'b1;
        version_q = '0;
        page_type_q = '0;
        granule_q = '0;
        serial_q = '0;
        sequence_q = '0;
        crc_in_header = '0;
        seg_total = '0;
        seg_seen = '0;
        length_total = '0;
        payload_left = '0;
        page_crc = '0;
    endtask

    task automatic predict_stream_byte(input logic [7:0] b, input logic eoi);
        result_t r;
        int      i;
        logic    finish;
        logic    done;
        logic    pv;
        logic [1:0] st;
        finish = 1'b0;
        done = 1'b0;
        pv = 1'b0;
        st = STATUS_OK;
        if (parse_phase == PH_SEGS) begin
            page_crc = page_crc_step(page_crc, b);
            length_total = length_total + {8'h00, b};
            seg_seen = seg_seen + 8'd1;
            if (seg_seen == seg_total) begin
                if (length_total == 0) begin
                    finish = 1'b1;
                end else begin
                    payload_left = length_total;
                    parse_phase = PH_DATA;
                end
            end
        end else if (parse_phase == PH_DATA) begin
            page_crc = page_crc_step(page_crc, b);
            pv = 1'b1;
            payload_left = payload_left - 16'd1;
            if (payload_left == 0) begin
                finish = 1'b1;
            end
        end else begin
            i = (header_pos >= HDR_LEN) ? 0 : int'(header_pos);
            if (i == 0) begin
                clear_page_state();
            end
            page_crc = page_crc_step(page_crc,
                                     (i >= IDX_CRC && i < IDX_CRC + 4) ? 8'h00 : b);
            if (i < 4 && b != CAPTURE_PATTERN[i]) begin
                sync_ok = 1'b0;
            end
            if (i == IDX_VERSION) begin
                version_q = b;
            end else if (i == IDX_TYPE) begin
                page_type_q = b;
            end else if (i >= IDX_GRANULE && i < IDX_SERIAL) begin
                granule_q[8*(i-IDX_GRANULE) +: 8] = b;
            end else if (i >= IDX_SERIAL && i < IDX_SEQUENCE) begin
                serial_q[8*(i-IDX_SERIAL) +: 8] = b;
            end else if (i >= IDX_SEQUENCE && i < IDX_CRC) begin
                sequence_q[8*(i-IDX_SEQUENCE) +: 8] = b;
            end else if (i >= IDX_CRC && i < IDX_CRC + 4) begin
                crc_in_header[8*(i-IDX_CRC) +: 8] = b;
            end
            if (i == HDR_LAST) begin
                seg_total = b;
                header_pos = '0;
                parse_phase = PH_HEADER;
                if (!sync_ok) begin
                    done = 1'b1;
                    st = STATUS_BAD_SIG;
                end else if (b == 0) begin
                    finish = 1'b1;
                end else begin
                    seg_seen = '0;
                    length_total = '0;
                    parse_phase = PH_SEGS;
                end
            end else begin
                header_pos = 5'(i + 1);
                parse_phase = PH_HEADER;
            end
        end
        if (finish) begin
            done = 1'b1;
            st = (page_crc == crc_in_header) ? STATUS_OK : STATUS_MISMATCH;
            parse_phase = PH_HEADER;
            header_pos = '0;
        end
        if (!done && eoi) begin
            done = 1'b1;
            st = STATUS_TRUNC;
            parse_phase = PH_HEADER;
            header_pos = '0;
        end
        if (done || pv) begin
            r.payload_valid = pv;
            r.payload_byte = pv ? b : 8'h00;
            r.page_done = done;
            r.status = done ? st : STATUS_OK;
            r.version = version_q;
            r.page_type = page_type_q;
            r.granule_position = granule_q;
            r.serial_number = serial_q;
            r.sequence_number = sequence_q;
            r.data_length = length_total;
            r.segment_count = seg_total;
            expected_results.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending: payload_byte %0h, status %0h",
                       m_payload_byte, m_status);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("payload_valid", 64'(want.payload_valid), 64'(m_payload_valid));
                check_field("payload_byte", 64'(want.payload_byte), 64'(m_payload_byte));
                check_field("page_done", 64'(want.page_done), 64'(m_page_done));
                check_field("status", 64'(want.status), 64'(m_status));
                check_field("version", 64'(want.version), 64'(m_version));
                check_field("page_type", 64'(want.page_type), 64'(m_page_type));
                check_field("granule_position", want.granule_position, m_granule_position);
                check_field("serial_number", 64'(want.serial_number), 64'(m_serial_number));
                check_field("sequence_number", 64'(want.sequence_number),
                            64'(m_sequence_number));
                check_field("data_length", 64'(want.data_length), 64'(m_data_length));
                check_field("segment_count", 64'(want.segment_count), 64'(m_segment_count));
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_stream_byte = b;
        s_end_of_input = eoi;
        do @(posedge aclk); while (!s_ready);
        predict_stream_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_page(input int last, input logic eoi_last);
        for (int k = 0; k <= last; k++) begin
            send_byte(page_bytes[k], eoi_last && (k == last));
        end
    endtask

    task automatic make_page(input int nseg, input int first_lace, input int lace_max,
                             input int fill);
        int          total;
        int          lace;
        logic [7:0]  value;
        logic [31:0] crc;
        page_bytes.delete();
        total = 0;
        for (int k = 0; k < 4; k++) begin
            page_bytes.push_back(CAPTURE_PATTERN[k]);
        end
        for (int k = 4; k < IDX_CRC + 4 + 22; k++) begin
            if (k >= IDX_CRC && k < IDX_CRC + 4) begin
                value = 8'h00;
            end else if (fill == FILL_ZERO) begin
                value = 8'h00;
            end else if (fill == FILL_ONES) begin
                value = 8'hff;
            end else begin
                value = 8'($urandom_range(255));
            end
            if (k < HDR_LAST) begin
                page_bytes.push_back(value);
            end
        end
        page_bytes.push_back(8'(nseg));
        for (int k = 0; k < nseg; k++) begin
            lace = (k == 0 && first_lace != NO_LACE) ? first_lace : $urandom_range(lace_max);
            page_bytes.push_back(8'(lace));
            total += lace;
        end
        for (int k = 0; k < total; k++) begin
            if (fill == FILL_ZERO) begin
                page_bytes.push_back(8'h00);
            end else if (fill == FILL_ONES) begin
                page_bytes.push_back(8'hff);
            end else begin
                page_bytes.push_back(8'($urandom_range(255)));
            end
        end
        crc = '0;
        foreach (page_bytes[k]) begin
            crc = page_crc_step(crc, page_bytes[k]);
        end
        for (int k = 0; k < 4; k++) begin
            page_bytes[IDX_CRC + k] = crc[8*k +: 8];
        end
    endtask

    task automatic wait_drain();
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic test_good_pages();
        make_page(1, 1, 0, FILL_ONES);
        send_page(page_bytes.size() - 1, 1'b0);
        make_page(2, 3, 3, FILL_ZERO);
        send_page(page_bytes.size() - 1, 1'b0);
        make_page(3, NO_LACE, 8, FILL_RANDOM);
        send_page(page_bytes.size() - 1, 1'b1);
        make_page(255, 255, 0, FILL_RANDOM);
        send_page(page_bytes.size() - 1, 1'b0);
    endtask

    task automatic test_empty_pages();
        make_page(0, NO_LACE, 0, FILL_RANDOM);
        send_page(page_bytes.size() - 1, 1'b0);
        make_page(3, 0, 0, FILL_RANDOM);
        send_page(page_bytes.size() - 1, 1'b0);
        make_page(0, NO_LACE, 0, FILL_ONES);
        send_page(page_bytes.size() - 1, 1'b1);
    endtask

    task automatic test_bad_signature();
        for (int k = 0; k < 4; k++) begin
            make_page(1, 2, 2, FILL_RANDOM);
            page_bytes[k] = ~page_bytes[k];
            send_page(int'(HDR_LAST), k == 3);
        end
    endtask

    task automatic test_checksum_mismatch();
        make_page(2, 4, 4, FILL_RANDOM);
        page_bytes[page_bytes.size() - 2] ^= 8'h10;
        send_page(page_bytes.size() - 1, 1'b0);
        make_page(1, 2, 0, FILL_RANDOM);
        page_bytes[IDX_CRC + 3] ^= 8'h80;
        send_page(page_bytes.size() - 1, 1'b0);
        make_page(0, NO_LACE, 0, FILL_RANDOM);
        page_bytes[IDX_VERSION + 1] ^= 8'h01;
        send_page(page_bytes.size() - 1, 1'b0);
    endtask

    task automatic test_truncation();
        make_page(2, 3, 3, FILL_RANDOM);
        send_page(0, 1'b1);
        make_page(2, 3, 3, FILL_RANDOM);
        send_page(13, 1'b1);
        make_page(4, 5, 5, FILL_RANDOM);
        send_page(HDR_LEN + 1, 1'b1);
        make_page(2, 6, 6, FILL_RANDOM);
        send_page(HDR_LEN + 2 + 2, 1'b1);
    endtask

    task automatic test_random_stream(input int sender_pct, input int receiver_pct,
                                      input int budget);
        int start;
        int kind;
        int nseg;
        int lace_max;
        int first_lace;
        int data_start;
        int idx;
        int count;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            if ($urandom_range(19) == 0) begin
                nseg = $urandom_range(5, 255);
                first_lace = $urandom_range(40);
                lace_max = 0;
            end else begin
                nseg = $urandom_range(4);
                first_lace = NO_LACE;
                lace_max = ($urandom_range(29) == 0) ? 255 : 12;
            end
            make_page(nseg, first_lace, lace_max, FILL_RANDOM);
            data_start = HDR_LEN + nseg;
            kind = $urandom_range(99);
            if (kind < 62) begin
                send_page(page_bytes.size() - 1, $urandom_range(9) == 0);
            end else if (kind < 74) begin
                if (page_bytes.size() > data_start && $urandom_range(1) == 1) begin
                    idx = $urandom_range(data_start, page_bytes.size() - 1);
                end else begin
                    idx = $urandom_range(4, IDX_CRC + 3);
                end
                page_bytes[idx] ^= 8'(1 << $urandom_range(7));
                send_page(page_bytes.size() - 1, 1'b0);
            end else if (kind < 82) begin
                idx = $urandom_range(3);
                page_bytes[idx] ^= 8'($urandom_range(1, 255));
                send_page(int'(HDR_LAST), $urandom_range(4) == 0);
            end else if (kind < 92) begin
                send_page($urandom_range(page_bytes.size() - 2), 1'b1);
            end else begin
                count = $urandom_range(1, 30);
                for (int k = 0; k < count; k++) begin
                    send_byte(8'($urandom_range(255)), k == count - 1);
                end
            end
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_stream_byte = 8'h00;
        s_end_of_input = 1'b0;
        aresetn = 1'b0;
        parse_phase = PH_HEADER;
        header_pos = '0;
        clear_page_state();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 71;
        test_good_pages();
        test_empty_pages();
        test_bad_signature();
        test_checksum_mismatch();
        test_truncation();
        test_random_stream(25, 71, 200);
        test_random_stream(71, 25, 200);
        test_random_stream(0, 0, 200);

        @(negedge aclk);
        s_valid = 1'b0;
        wait_drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
